FILE: hdl/rag_pkg.sv
// Package for the rational ALU: widths, operation codes and sequencer states.
// Used by rag_div and rational_alu_with_gcd_reduce; depends on nothing.
`timescale 1ns / 1ps
package rag_pkg;
   localparam int OPW   = 16;            // operand width
   localparam int NW    = 2 * OPW + 1;   // magnitude width of products and sums
   localparam int NUM_W = 33;            // result numerator width
   localparam int DEN_W = 31;            // result denominator width
   localparam int KW    = $clog2(NW + 1);

   typedef enum logic [2:0] {
      FN_ADD = 3'd0,
      FN_SUB = 3'd1,
      FN_MUL = 3'd2,
      FN_DIV = 3'd3,
      FN_RED = 3'd4
   } func_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_CHECK, S_TWOS, S_GCD,
      S_DIVN, S_WAITN, S_DIVD, S_WAITD, S_DONE
   } state_type;
endpackage

FILE: hdl/rag_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rag_pkg for the magnitude width.
`timescale 1ns / 1ps
module rag_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [rag_pkg::NW-1:0] dividend,
   input  logic [rag_pkg::NW-1:0] divisor,
   output logic                 done,
   output logic [rag_pkg::NW-1:0] quotient
);
   import rag_pkg::*;

   logic [NW-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [NW:0]   sh, diff;

   always_comb begin
      sh      = {rem_ff, quo_ff[NW-1]};
      diff    = sh - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = KW'(NW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[NW]) begin
            rem_in = diff[NW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = sh[NW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - KW'(1);
         if (cnt_ff == KW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: hdl/rational_alu_with_gcd_reduce.sv
// Top level of the rational ALU: multiply sequence, binary gcd and exact division.
// Depends on rag_pkg and rag_div.
//
//  channel  ports                         handshake
//  request  req_func, req_a_*, req_b_*    start high while busy low
//  result   rsp_res_num, rsp_res_den      rsp_valid strobe, one cycle
//
// A request with a nonzero numerator and denominator uses the shared 16x16 multiplier in
// S_MUL0, S_MUL1 (add and subtract only) and S_MUL2, then takes one gcd step per cycle,
// then runs two divisions by the gcd.
// A zero numerator or denominator skips the gcd and the divisions; the sequencer then
// goes from S_CHECK straight to S_DONE, which strobes the result.
// Synchronous reset returns the sequencer to idle. The receiver cannot stall;
// busy stays high from the accepted request until its result strobe.
`timescale 1ns / 1ps
module rational_alu_with_gcd_reduce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_func,
   input  logic signed [rag_pkg::OPW-1:0] req_a_num,
   input  logic signed [rag_pkg::OPW-1:0] req_a_den,
   input  logic signed [rag_pkg::OPW-1:0] req_b_num,
   input  logic signed [rag_pkg::OPW-1:0] req_b_den,
   output logic                      rsp_valid,
   output logic signed [rag_pkg::NUM_W-1:0] rsp_res_num,
   output logic [rag_pkg::DEN_W-1:0] rsp_res_den
);
   import rag_pkg::*;

   state_type state_ff, state_in;
   logic [2:0]     func_ff, func_in;
   logic [OPW-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [NW-1:0]  p0_ff, p0_in, p1_ff, p1_in, nm_ff, nm_in, dm_ff, dm_in;
   logic           p0n_ff, p0n_in, p1n_ff, p1n_in, nn_ff, nn_in, dn_ff, dn_in;
   logic [NW-1:0]  u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [NUM_W-1:0] num_ff, num_in, num_tmp;
   logic [DEN_W-1:0] den_ff, den_in;

   logic           fadd, fsub, fmul, fdiv, fsum;
   logic [OPW-1:0] xm, ym;
   logic           xn, yn;
   logic [2*OPW-1:0] prod;
   logic           pneg, q1n;
   logic           div_start, div_done;
   logic [NW-1:0]  div_a, div_q;

   function automatic logic [OPW:0] sm_of(input logic [OPW-1:0] raw);
      logic [OPW-1:0] m;
      m = raw[OPW-1] ? (~raw + OPW'(1)) : raw;
      return {raw[OPW-1], m};
   endfunction

   assign fadd = (func_ff == FN_ADD);
   assign fsub = (func_ff == FN_SUB);
   assign fmul = (func_ff == FN_MUL);
   assign fdiv = (func_ff == FN_DIV);
   assign fsum = fadd || fsub;

   // Operand selection for the shared multiplier. Reduce multiplies by one.
   always_comb begin
      {xn, xm} = sm_of(an_ff);
      {yn, ym} = sm_of(bd_ff);
      case (state_ff)
         S_MUL0: begin
            {xn, xm} = sm_of(an_ff);
            if (fmul) {yn, ym} = sm_of(bn_ff);
            else if (fsum || fdiv) {yn, ym} = sm_of(bd_ff);
            else begin
               yn = 1'b0;
               ym = OPW'(1);
            end
         end
         S_MUL1: begin
            {xn, xm} = sm_of(bn_ff);
            {yn, ym} = sm_of(ad_ff);
         end
         S_MUL2: begin
            {xn, xm} = sm_of(ad_ff);
            if (fdiv) {yn, ym} = sm_of(bn_ff);
            else if (fsum || fmul) {yn, ym} = sm_of(bd_ff);
            else begin
               yn = 1'b0;
               ym = OPW'(1);
            end
         end
         default: ;
      endcase
      prod = xm * ym;
      pneg = (xn != yn) && (prod != '0);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start) state_in = S_MUL0;
         S_MUL0:  state_in = fsum ? S_MUL1 : S_MUL2;
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_COMB;
         S_COMB:  state_in = S_CHECK;
         S_CHECK: state_in = (dm_ff == '0 || nm_ff == '0) ? S_DONE : S_TWOS;
         S_TWOS:  if (u_ff[0] || v_ff[0]) state_in = S_GCD;
         S_GCD:   if (u_ff == '0 || v_ff == '0) state_in = S_DIVN;
         S_DIVN:  state_in = S_WAITN;
         S_WAITN: if (div_done) state_in = S_DIVD;
         S_DIVD:  state_in = S_WAITD;
         S_WAITD: if (div_done) state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      busy      = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_DONE);
      div_start = (state_ff == S_DIVN) || (state_ff == S_DIVD);
      div_a     = (state_ff == S_DIVD) ? dm_ff : nm_ff;
   end

   // Datapath.
   always_comb begin
      func_in = func_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      p0_in = p0_ff; p0n_in = p0n_ff; p1_in = p1_ff; p1n_in = p1n_ff;
      nm_in = nm_ff; nn_in = nn_ff; dm_in = dm_ff; dn_in = dn_ff;
      u_in = u_ff; v_in = v_ff; g_in = g_ff; k_in = k_ff;
      num_in = num_ff; den_in = den_ff;
      q1n = fsub ? (!p1n_ff && p1_ff != '0) : p1n_ff;
      num_tmp = NUM_W'(nm_ff);
      case (state_ff)
         S_IDLE: begin
            func_in = req_func;
            an_in = req_a_num; ad_in = req_a_den;
            bn_in = req_b_num; bd_in = req_b_den;
         end
         S_MUL0: begin
            p0_in = NW'(prod); p0n_in = pneg;
         end
         S_MUL1: begin
            p1_in = NW'(prod); p1n_in = pneg;
         end
         S_MUL2: begin
            dm_in = NW'(prod); dn_in = pneg;
         end
         S_COMB: begin
            if (!fsum) begin
               nm_in = p0_ff; nn_in = p0n_ff;
            end else if (p0n_ff == q1n) begin
               nm_in = p0_ff + p1_ff; nn_in = p0n_ff;
            end else if (p0_ff >= p1_ff) begin
               nm_in = p0_ff - p1_ff; nn_in = p0n_ff;
            end else begin
               nm_in = p1_ff - p0_ff; nn_in = q1n;
            end
         end
         S_CHECK: begin
            nn_in = (nn_ff != dn_ff) && (nm_ff != '0);
            u_in  = nm_ff;
            v_in  = dm_ff;
            k_in  = '0;
            if (dm_ff == '0) begin
               num_in = '0;
               den_in = DEN_W'(1);
            end else if (nm_ff == '0) begin
               num_in = '0;
               den_in = DEN_W'(dm_ff);
            end
         end
         S_TWOS: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end
         end
         S_GCD: begin
            // Binary gcd: strip factors of two, subtract the smaller odd value.
            if (u_ff == '0 || v_ff == '0) g_in = (u_ff | v_ff) << k_ff;
            else if (!u_ff[0]) u_in = u_ff >> 1;
            else if (!v_ff[0]) v_in = v_ff >> 1;
            else if (u_ff >= v_ff) u_in = (u_ff - v_ff) >> 1;
            else v_in = (v_ff - u_ff) >> 1;
         end
         S_WAITN: if (div_done) nm_in = div_q;
         S_WAITD: begin
            if (div_done) begin
               num_in = nn_ff ? (NUM_W'(0) - num_tmp) : num_tmp;
               den_in = DEN_W'(div_q);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      p0_ff <= p0_in; p0n_ff <= p0n_in; p1_ff <= p1_in; p1n_ff <= p1n_in;
      nm_ff <= nm_in; nn_ff <= nn_in; dm_ff <= dm_in; dn_ff <= dn_in;
      u_ff <= u_in; v_ff <= v_in; g_ff <= g_in; k_ff <= k_in;
      num_ff <= num_in; den_ff <= den_in;
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   rag_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_res_num = num_ff;
   assign rsp_res_den = den_ff;
endmodule
